/* rtl/core/epfa_pkg.sv */
// ----------------------------------------------------------------------------
// epfa_pkg
// Shared types and constants for the edge period frequency averager.
// ----------------------------------------------------------------------------
package epfa_pkg;

    localparam int KIND_W    = 2;
    localparam int CLK_W     = 27;
    localparam int STAMP_W   = 32;
    localparam int SUM_W     = 48;
    localparam int AVG_W     = 16;
    localparam int STEP_W    = $clog2(SUM_W + 1);

    localparam logic [CLK_W-1:0]  CLOCK_RESET = CLK_W'(10000000);

    localparam logic [KIND_W-1:0] KIND_EDGE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

    // Accumulator command from the sequencer
    typedef struct packed {
        logic clear;
        logic add;
    } acc_cmd_t;

endpackage

/* rtl/core/edge_period_frequency_averager.sv */
// ----------------------------------------------------------------------------
// edge_period_frequency_averager
// Reciprocal frequency counter that averages timer_clock / period over a
// window of timestamped sensor edges.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request per item: an
//   edge (kind, edge_rising, timestamp), a start or a finish. in_stall is
//   high while the block works on a request; one request is handled at a
//   time.
//   Output channel (out_valid / out_stall) carries one result per finish
//   request: average_freq and no_samples. The result sits in an output
//   register, so a new request is taken while the result waits.
//   Config channel (cfg_valid / cfg_ready) writes timer_clock_hz; it is
//   always ready. It must be written only while the block is idle; the
//   block itself does not enforce this.
// Sequence: falling edge, start and ignored edge finish in the idle state.
//   Rising edge with a sample: idle, divide (27 quotient bits), accumulate.
//   Finish: idle, divide (48 quotient bits), emit to the output register;
//   idle then emit when no samples were taken. The divide time is set by
//   the shared radix-2 divider, which retires one quotient bit per cycle.
// Reset clears the edge state, sum and count and loads timer_clock_hz with
// 10000000. A stalled result holds in the output register; a finish that
// completes behind it waits until the register frees.
// ----------------------------------------------------------------------------
module edge_period_frequency_averager #(
    parameter int TIME_WIDTH  = 32,
    parameter int COUNT_WIDTH = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // input requests
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [epfa_pkg::KIND_W-1:0]  kind,
    input  logic                         edge_rising,
    input  logic [epfa_pkg::STAMP_W-1:0] timestamp,
    // results
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [epfa_pkg::AVG_W-1:0]   average_freq,
    output logic                         no_samples,
    // configuration
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [epfa_pkg::CLK_W-1:0]   cfg_data
);
    import epfa_pkg::*;

    localparam int DIV_W = (TIME_WIDTH > COUNT_WIDTH) ? TIME_WIDTH : COUNT_WIDTH;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_ACCUM = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [CLK_W-1:0]      clock_hz_reg;
    logic [TIME_WIDTH-1:0] rise_time_reg, rise_time_next;
    logic [TIME_WIDTH-1:0] fall_time_reg, fall_time_next;
    logic                  seen_rise_reg, seen_rise_next;  // last polarity rising
    logic                  seen_fall_reg, seen_fall_next;  // last polarity falling
    logic                  is_finish_reg, is_finish_next;  // divider runs for a finish
    logic                  empty_reg, empty_next;

    logic                  out_valid_reg, out_valid_next;
    logic [AVG_W-1:0]      avg_reg, avg_next;
    logic                  no_samp_reg, no_samp_next;

    logic                  accept;
    logic [TIME_WIDTH-1:0] stamp;
    logic [TIME_WIDTH-1:0] period;

    logic                  div_start;
    logic [SUM_W-1:0]      div_dividend;
    logic [DIV_W-1:0]      div_divisor;
    logic [STEP_W-1:0]     div_steps;
    logic                  div_busy;
    logic                  div_done;
    logic [SUM_W-1:0]      div_quo;

    acc_cmd_t              acc_cmd;
    logic [SUM_W-1:0]      acc_sum;
    logic [COUNT_WIDTH-1:0] acc_count;

    assign accept = in_valid && !in_stall;
    assign stamp  = TIME_WIDTH'(timestamp);
    assign period = stamp - rise_time_reg;

    // Configuration: always ready, write the clock rate on each request
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg <= CLOCK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            clock_hz_reg <= cfg_data;
        end
    end

    // Sequencer and edge bookkeeping
    always_comb
    begin
        state_next     = state_reg;
        rise_time_next = rise_time_reg;
        fall_time_next = fall_time_reg;
        seen_rise_next = seen_rise_reg;
        seen_fall_next = seen_fall_reg;
        is_finish_next = is_finish_reg;
        empty_next     = empty_reg;
        out_valid_next = out_valid_reg && out_stall;
        avg_next       = avg_reg;
        no_samp_next   = no_samp_reg;
        div_start      = 1'b0;
        div_dividend   = {clock_hz_reg, {(SUM_W - CLK_W){1'b0}}};
        div_divisor    = DIV_W'(period);
        div_steps      = STEP_W'(CLK_W);
        acc_cmd        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_EDGE)
                    begin
                        // Drop an edge that repeats the previous polarity
                        if (edge_rising && !seen_rise_reg)
                        begin
                            seen_rise_next = 1'b1;
                            seen_fall_next = 1'b0;
                            rise_time_next = stamp;
                            if ((fall_time_reg != '0) && (period != '0))
                            begin
                                div_start      = 1'b1;
                                is_finish_next = 1'b0;
                                state_next     = ST_DIV;
                            end
                        end
                        else if (!edge_rising && !seen_fall_reg)
                        begin
                            seen_rise_next = 1'b0;
                            seen_fall_next = 1'b1;
                            fall_time_next = stamp;
                        end
                    end
                    else if (kind == KIND_START)
                    begin
                        acc_cmd.clear = 1'b1;
                    end
                    else if (kind == KIND_FINISH)
                    begin
                        if (acc_count == '0)
                        begin
                            empty_next = 1'b1;
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            empty_next     = 1'b0;
                            is_finish_next = 1'b1;
                            div_start      = 1'b1;
                            div_dividend   = acc_sum;
                            div_divisor    = DIV_W'(acc_count);
                            div_steps      = STEP_W'(SUM_W);
                            state_next     = ST_DIV;
                        end
                    end
                end
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = is_finish_reg ? ST_EMIT : ST_ACCUM;
                end
            end

            ST_ACCUM:
            begin
                acc_cmd.add = 1'b1;
                state_next  = ST_IDLE;
            end

            ST_EMIT:
            begin
                // Load the output register once the previous result is taken
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    avg_next       = empty_reg ? '0 : div_quo[AVG_W-1:0];
                    no_samp_next   = empty_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rise_time_reg <= '0;
            fall_time_reg <= '0;
            seen_rise_reg <= 1'b0;
            seen_fall_reg <= 1'b0;
            is_finish_reg <= 1'b0;
            empty_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rise_time_reg <= rise_time_next;
            fall_time_reg <= fall_time_next;
            seen_rise_reg <= seen_rise_next;
            seen_fall_reg <= seen_fall_next;
            is_finish_reg <= is_finish_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        avg_reg     <= avg_next;
        no_samp_reg <= no_samp_next;
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign average_freq = avg_reg;
    assign no_samples   = no_samp_reg;

    // Shared divider: clock / period on rising edges, sum / count on finish
    epfa_divider #(
        .DIVISOR_W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // The edge quotient has at most CLK_W bits and sits at the bottom
    epfa_accum #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_acc (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (acc_cmd),
        .freq  (div_quo[CLK_W-1:0]),
        .sum   (acc_sum),
        .count (acc_count)
    );

`ifndef ASSERT_OFF
    // The divider never runs while the block takes requests
    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !div_busy)
        else $error("divider busy while idle");

    // A divider completion only happens in the divide state
    a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider done outside divide state");

    // An empty window reports zero average
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && no_samples) |-> (average_freq == '0))
        else $error("nonzero average with no samples");

    // Saturated count stays saturated until a start
    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        ((acc_count == {COUNT_WIDTH{1'b1}}) && !acc_cmd.clear)
            |=> (acc_count == {COUNT_WIDTH{1'b1}}))
        else $error("sample count wrapped");
`endif

endmodule

/* rtl/core/epfa_divider.sv */
// ----------------------------------------------------------------------------
// epfa_divider
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module epfa_divider #(
    parameter int DIVISOR_W = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [epfa_pkg::SUM_W-1:0]  dividend,
    input  logic [DIVISOR_W-1:0]        divisor,
    input  logic [epfa_pkg::STEP_W-1:0] steps,
    output logic                        busy,
    output logic                        done,
    output logic [epfa_pkg::SUM_W-1:0]  quotient
);
    import epfa_pkg::*;

    logic                 busy_reg, busy_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dsr_reg, dsr_next;
    logic [DIVISOR_W:0]   shifted;
    logic [DIVISOR_W:0]   diff;
    logic                 qbit;

    // Trial subtract of the divisor from the shifted partial remainder
    assign shifted = {rem_reg, quo_reg[SUM_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign qbit    = ~diff[DIVISOR_W];

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = steps;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[SUM_W-2:0], qbit};
            rem_next  = qbit ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign done     = busy_reg && (step_reg == STEP_W'(1));
    assign quotient = quo_reg;

endmodule

/* rtl/core/epfa_accum.sv */
// ----------------------------------------------------------------------------
// epfa_accum
// Saturating frequency sum and sample count.
// ----------------------------------------------------------------------------
module epfa_accum #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  epfa_pkg::acc_cmd_t         cmd,
    input  logic [epfa_pkg::CLK_W-1:0] freq,
    output logic [epfa_pkg::SUM_W-1:0] sum,
    output logic [COUNT_WIDTH-1:0]     count
);
    import epfa_pkg::*;

    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [SUM_W:0]         sum_wide;

    assign sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(freq);

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (cmd.clear)
        begin
            sum_next   = '0;
            count_next = '0;
        end
        else if (cmd.add)
        begin
            // Saturate both at all ones
            sum_next = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
            if (count_reg != {COUNT_WIDTH{1'b1}})
            begin
                count_next = count_reg + COUNT_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    assign sum   = sum_reg;
    assign count = count_reg;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for edge_period_frequency_averager. A short table of
// hand-picked requests covers reset state, ignored kinds and polarities,
// zero periods, wrap-around and the gating falling edge. Random measurement
// windows follow under several timer clock settings. A local model of the
// averager predicts each finish result that the table does not type in. Both
// channels idle and stall at random, and one long output hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb;
    import epfa_pkg::*;

    localparam int                COUNT_W         = 24;
    localparam int                DIR_ROWS        = 24;
    localparam int                HOLD_OFF_CYCLES = 400;
    // Longer than the slowest request (a finish with samples)
    localparam int                SETTLE_CYCLES   = 64;
    localparam int                CYCLE_LIMIT     = 300000;
    localparam logic [KIND_W-1:0] KIND_UNUSED     = 2'd3;
    localparam logic [SUM_W-1:0]  SUM_FULL        = '1;
    localparam logic [COUNT_W-1:0] COUNT_FULL     = '1;

    typedef enum logic [1:0] {POL_NONE, POL_FALL, POL_RISE} polarity_t;

    typedef struct packed {
        logic [AVG_W-1:0] freq;
        logic             empty;
    } average_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic               rising;
        logic [STAMP_W-1:0] stamp;
        logic               typed;
        average_t           result;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [KIND_W-1:0]    kind;
    logic                 edge_rising;
    logic [STAMP_W-1:0]   timestamp;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [AVG_W-1:0]     average_freq;
    logic                 no_samples;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CLK_W-1:0]     cfg_data;

    // Model of the averager, updated in request acceptance order
    logic [CLK_W-1:0]     tick_rate  = CLOCK_RESET;
    logic [STAMP_W-1:0]   rise_stamp = '0;
    logic [STAMP_W-1:0]   fall_stamp = '0;
    polarity_t            edge_pol   = POL_NONE;
    logic [SUM_W-1:0]     freq_sum   = '0;
    logic [COUNT_W-1:0]   sample_cnt = '0;
    average_t             pending_avgs[$];

    logic                 steady   = 1'b0;   // no idling on either side
    logic                 hold_off = 1'b0;   // long output hold-off
    event                 hold_ev;
    int                   rx_wait  = 0;
    int                   cycles   = 0;
    int                   errors   = 0;
    int                   requests_sent = 0;
    int                   results_seen  = 0;
    int                   settings_done = 0;
    logic [STAMP_W-1:0]   stream_stamp;
    logic [CLK_W-1:0]     rate_plan [6] = '{27'd0, 27'd1, '1, 27'd100000000,
                                            27'd0, CLOCK_RESET};

    // Directed rows. Results are typed in only where they are obvious; the
    // rest come from the model.
    dir_row_t dir_rows [DIR_ROWS] = '{
        // empty right after reset
        '{KIND_FINISH, 1'b0, 32'h0000_0000, 1'b1, '{16'd0, 1'b1}},
        // unused kind: no effect at all
        '{KIND_UNUSED, 1'b1, 32'hFFFF_FFFF, 1'b0, '{16'd0, 1'b0}},
        // rising before any falling edge: no sample
        '{KIND_EDGE,   1'b1, 32'd100,       1'b0, '{16'd0, 1'b0}},
        // falling at time zero keeps the gate closed
        '{KIND_EDGE,   1'b0, 32'h0000_0000, 1'b0, '{16'd0, 1'b0}},
        '{KIND_EDGE,   1'b1, 32'd200,       1'b0, '{16'd0, 1'b0}},
        '{KIND_FINISH, 1'b0, 32'h0000_0000, 1'b1, '{16'd0, 1'b1}},
        // nonzero falling time opens the gate; a repeated falling is dropped
        '{KIND_EDGE,   1'b0, 32'hFFFF_FFFF, 1'b0, '{16'd0, 1'b0}},
        '{KIND_EDGE,   1'b0, 32'd5,         1'b0, '{16'd0, 1'b0}},
        // period 1000 at 10 MHz gives 10000
        '{KIND_EDGE,   1'b1, 32'd1200,      1'b0, '{16'd0, 1'b0}},
        '{KIND_FINISH, 1'b0, 32'h0000_0000, 1'b1, '{16'd10000, 1'b0}},
        // start and finish ignore the polarity bit
        '{KIND_START,  1'b1, 32'hFFFF_FFFF, 1'b0, '{16'd0, 1'b0}},
        '{KIND_FINISH, 1'b1, 32'hFFFF_FFFF, 1'b1, '{16'd0, 1'b1}},
        // zero period: rising time moves, no sample
        '{KIND_EDGE,   1'b0, 32'd1300,      1'b0, '{16'd0, 1'b0}},
        '{KIND_EDGE,   1'b1, 32'd1200,      1'b0, '{16'd0, 1'b0}},
        '{KIND_FINISH, 1'b0, 32'h0000_0000, 1'b1, '{16'd0, 1'b1}},
        // period one: full clock rate, truncated to 16 bits
        '{KIND_EDGE,   1'b0, 32'd1400,      1'b0, '{16'd0, 1'b0}},
        '{KIND_EDGE,   1'b1, 32'd1201,      1'b0, '{16'd0, 1'b0}},
        '{KIND_FINISH, 1'b0, 32'h0000_0000, 1'b0, '{16'd0, 1'b0}},
        // backwards time wraps to a huge period: adds zero but counts
        '{KIND_EDGE,   1'b0, 32'd2000,      1'b0, '{16'd0, 1'b0}},
        '{KIND_EDGE,   1'b1, 32'd1200,      1'b0, '{16'd0, 1'b0}},
        '{KIND_FINISH, 1'b0, 32'h0000_0000, 1'b0, '{16'd0, 1'b0}},
        // falling back at zero closes the gate again
        '{KIND_EDGE,   1'b0, 32'h0000_0000, 1'b0, '{16'd0, 1'b0}},
        '{KIND_EDGE,   1'b1, 32'd5000,      1'b0, '{16'd0, 1'b0}},
        '{KIND_FINISH, 1'b1, 32'hFFFF_FFFF, 1'b0, '{16'd0, 1'b0}}
    };

    edge_period_frequency_averager #(
        .TIME_WIDTH  (STAMP_W),
        .COUNT_WIDTH (COUNT_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .edge_rising  (edge_rising),
        .timestamp    (timestamp),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .average_freq (average_freq),
        .no_samples   (no_samples),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    // Advance the model by one accepted request; flag when it yields a result.
    function automatic void average_update(input logic [KIND_W-1:0] k,
                                           input logic rising,
                                           input logic [STAMP_W-1:0] stamp,
                                           output logic produced,
                                           output average_t outcome);
        polarity_t          pol;
        logic [STAMP_W-1:0] period;
        logic [SUM_W-1:0]   freq;
        produced = 1'b0;
        outcome  = '0;
        case (k)
            KIND_EDGE:
            begin
                pol = rising ? POL_RISE : POL_FALL;
                // drop an edge that repeats the previous polarity
                if (pol != edge_pol)
                begin
                    edge_pol = pol;
                    if (pol == POL_FALL)
                        fall_stamp = stamp;
                    else
                    begin
                        if (fall_stamp != '0)
                        begin
                            period = stamp - rise_stamp;
                            if (period != '0)
                            begin
                                freq = SUM_W'(tick_rate) / SUM_W'(period);
                                if (freq > SUM_FULL - freq_sum)
                                    freq_sum = SUM_FULL;
                                else
                                    freq_sum = freq_sum + freq;
                                if (sample_cnt != COUNT_FULL)
                                    sample_cnt = sample_cnt + COUNT_W'(1);
                            end
                        end
                        rise_stamp = stamp;
                    end
                end
            end
            KIND_START:
            begin
                freq_sum   = '0;
                sample_cnt = '0;
            end
            KIND_FINISH:
            begin
                produced = 1'b1;
                if (sample_cnt == '0)
                    outcome.empty = 1'b1;
                else
                    outcome.freq = AVG_W'(freq_sum / SUM_W'(sample_cnt));
            end
            default:
            begin
            end
        endcase
    endfunction

    // Offer one request after a random gap and hold it until taken. Valid is
    // only lowered when a gap follows, so back-to-back requests keep it high.
    task automatic send_request(input logic [KIND_W-1:0] k, input logic rising,
                                input logic [STAMP_W-1:0] stamp,
                                input logic typed, input average_t typed_avg);
        int       gap;
        logic     produced;
        average_t outcome;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        edge_rising <= rising;
        timestamp   <= stamp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        average_update(k, rising, stamp, produced, outcome);
        if (produced)
            pending_avgs.push_back(typed ? typed_avg : outcome);
        if (k != KIND_UNUSED)
            requests_sent++;
    endtask

    // Hold the input idle until every result is back, then let any trailing
    // rising-edge divide finish.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_avgs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_tick_rate(input logic [CLK_W-1:0] rate);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= rate;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tick_rate = rate;
        settings_done++;
    endtask

    // One measurement window: start, alternating falling and rising edges
    // with random periods (including zero and huge), then finish.
    task automatic run_window(input int pairs);
        logic [STAMP_W-1:0] period;
        send_request(KIND_START, 1'($urandom), $urandom, 1'b0, '0);
        for (int p = 0; p < pairs; p++)
        begin
            case ($urandom_range(0, 9))
                0:       period = '0;
                1:       period = $urandom;
                2:       period = $urandom_range(1, 20);
                default: period = $urandom_range(1, 4000);
            endcase
            send_request(KIND_EDGE, 1'b0, stream_stamp + $urandom_range(1, 300),
                         1'b0, '0);
            // now and then repeat the falling edge; the block must drop it
            if ($urandom_range(0, 15) == 0)
                send_request(KIND_EDGE, 1'b0, $urandom, 1'b0, '0);
            stream_stamp = stream_stamp + period;
            send_request(KIND_EDGE, 1'b1, stream_stamp, 1'b0, '0);
        end
        send_request(KIND_FINISH, 1'($urandom), $urandom, 1'b0, '0);
    endtask

    // Compare one taken result with the oldest expected average.
    function automatic void check_average();
        average_t want;
        results_seen++;
        if (pending_avgs.size() == 0)
        begin
            $error("unexpected result: average_freq %0d no_samples %0b",
                   average_freq, no_samples);
            errors++;
        end
        else
        begin
            want = pending_avgs.pop_front();
            if (average_freq !== want.freq)
            begin
                $error("average_freq: expected %0d, got %0d", want.freq, average_freq);
                errors++;
            end
            if (no_samples !== want.empty)
            begin
                $error("no_samples: expected %0b, got %0b", want.empty, no_samples);
                errors++;
            end
        end
    endfunction

    // Result side: take a result, then stall a random number of cycles before
    // the next one. The long hold-off overrides everything while active.
    always @(posedge clk or negedge rst_n)
    begin : result_sink
        int next_wait;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_wait   <= 0;
        end
        else
        begin
            next_wait = rx_wait;
            if (out_valid && !out_stall)
            begin
                check_average();
                next_wait = steady ? 0 : $urandom_range(0, 6);
            end
            else if (next_wait > 0)
                next_wait = next_wait - 1;
            rx_wait   <= next_wait;
            out_stall <= hold_off || (next_wait > 0);
        end
    end

    // Count out the long hold-off on its own so the sender keeps pushing.
    initial
    begin
        @(hold_ev);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Watchdog: a hang or a lost result ends here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycles, pending_avgs.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : stimulus
        int budget;
        int windows;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        kind        <= KIND_EDGE;
        edge_rising <= 1'b0;
        timestamp   <= '0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at the reset clock rate
        for (int i = 0; i < DIR_ROWS; i++)
            send_request(dir_rows[i].kind, dir_rows[i].rising, dir_rows[i].stamp,
                         dir_rows[i].typed, dir_rows[i].result);

        // Random phases, one per clock setting: zero, one, widest, top of
        // range, a random rate, and back to the reset value
        rate_plan[4] = CLK_W'($urandom_range(1, 100000000));
        for (int ph = 0; ph < 6; ph++)
        begin
            write_tick_rate(rate_plan[ph]);
            stream_stamp = $urandom;
            // back up the block behind a long output stall in one phase
            if (ph == 1)
                -> hold_ev;
            budget  = requests_sent + 75;
            windows = 0;
            while (requests_sent < budget)
            begin
                steady = (ph == 1 && windows < 6) || ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 6))
                        send_request(2'($urandom), 1'($urandom), $urandom, 1'b0, '0);
                else
                begin
                    run_window($urandom_range(1, 8));
                    windows++;
                end
            end
        end
        steady = 1'b0;
        drain();

        $display("%0d requests over %0d clock settings, %0d averages checked",
                 requests_sent, settings_done + 1, results_seen);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* edge_period_frequency_averager.f */
rtl/core/epfa_pkg.sv
rtl/core/epfa_divider.sv
rtl/core/epfa_accum.sv
rtl/core/edge_period_frequency_averager.sv
tb/sv/tb.sv
